// ===== rtl/core/sbps_pkg.sv =====
// Shared types, phase codes and register indexes for the siren button pulse sequencer.
package sbps_pkg;

  // Sequencer phase codes
  localparam logic [2:0] PH_PRESS1 = 3'd0;
  localparam logic [2:0] PH_PRESS2 = 3'd1;
  localparam logic [2:0] PH_SHORT3 = 3'd2;
  localparam logic [2:0] PH_LONG3  = 3'd3;
  localparam logic [2:0] PH_GAP    = 3'd4;
  localparam logic [2:0] PH_IDLE   = 3'd5;

  // Bit positions of the button lines
  localparam int unsigned LINE_ONE   = 0;
  localparam int unsigned LINE_TWO   = 1;
  localparam int unsigned LINE_THREE = 2;

  // App request codes (siren three in the top bit)
  localparam logic [2:0] REQ_NONE  = 3'b000;
  localparam logic [2:0] REQ_ONE   = 3'b001;
  localparam logic [2:0] REQ_TWO   = 3'b010;
  localparam logic [2:0] REQ_THREE = 3'b100;

  // Configuration register indexes
  localparam logic [2:0] CFG_SWITCH_LOW    = 3'd0;
  localparam logic [2:0] CFG_SWITCH_CENTER = 3'd1;
  localparam logic [2:0] CFG_SWITCH_HIGH   = 3'd2;
  localparam logic [2:0] CFG_PRESS_TIME    = 3'd3;
  localparam logic [2:0] CFG_SHORT_PRESS   = 3'd4;
  localparam logic [2:0] CFG_LONG_PRESS    = 3'd5;
  localparam logic [2:0] CFG_GAP_TIME      = 3'd6;

  typedef struct packed {
    logic [11:0] switch_low_level;
    logic [11:0] switch_center_level;
    logic [11:0] switch_high_level;
    logic [15:0] press_time_ms;
    logic [15:0] short_press_ms;
    logic [15:0] long_press_ms;
    logic [15:0] gap_time_ms;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] now_ms;
    logic [11:0] rc_main_level;
    logic [11:0] rc_aux_level;
    logic [2:0]  app_requests;
  } poll_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] phase_start;
    logic        repeat_count;
    logic [11:0] last_rc_main;
    logic [11:0] last_rc_aux;
    logic [2:0]  last_app_requests;
    logic [2:0]  line_levels;
  } seq_state_t;

endpackage

// ===== rtl/core/sbps_step.sv =====
// Next-state logic for one poll: decode the poll, then advance the phase sequencer once.
module sbps_step import sbps_pkg::*; (
  input  cfg_t       cfg,
  input  poll_t      poll,
  input  seq_state_t cur,
  output seq_state_t nxt
);

  logic [2:0]  dec_phase;
  logic [31:0] dec_start;
  logic [31:0] elapsed;
  logic        lo_hit_main;
  logic        ce_hit_main;
  logic        hi_hit_main;
  logic        lo_was_main;
  logic        ce_was_main;
  logic        hi_was_main;

  // Level matches of the main receiver channel
  assign lo_hit_main = (poll.rc_main_level == cfg.switch_low_level);
  assign ce_hit_main = (poll.rc_main_level == cfg.switch_center_level);
  assign hi_hit_main = (poll.rc_main_level == cfg.switch_high_level);
  assign lo_was_main = (cur.last_rc_main == cfg.switch_low_level);
  assign ce_was_main = (cur.last_rc_main == cfg.switch_center_level);
  assign hi_was_main = (cur.last_rc_main == cfg.switch_high_level);

  // Decode the poll into a possible phase start
  always_comb begin
    dec_phase = cur.phase;
    dec_start = cur.phase_start;
    if (!poll.mode) begin
      priority if ((lo_hit_main && ce_was_main) || (ce_hit_main && lo_was_main)) begin
        dec_phase = PH_PRESS1;
        dec_start = poll.now_ms;
      end else if ((hi_hit_main && ce_was_main) || (ce_hit_main && hi_was_main)) begin
        dec_phase = PH_PRESS2;
        dec_start = poll.now_ms;
      end else if (((poll.rc_aux_level == cfg.switch_high_level) &&
                    (cur.last_rc_aux == cfg.switch_low_level)) ||
                   ((poll.rc_aux_level == cfg.switch_low_level) &&
                    (cur.last_rc_aux == cfg.switch_high_level))) begin
        dec_phase = PH_SHORT3;
        dec_start = poll.now_ms;
      end else begin
        dec_phase = cur.phase;
      end
    end else if (poll.app_requests != cur.last_app_requests) begin
      priority if (poll.app_requests == REQ_ONE) begin
        dec_phase = PH_PRESS1;
        dec_start = poll.now_ms;
      end else if (poll.app_requests == REQ_TWO) begin
        dec_phase = PH_PRESS2;
        dec_start = poll.now_ms;
      end else if (poll.app_requests == REQ_THREE) begin
        dec_phase = PH_SHORT3;
        dec_start = poll.now_ms;
      end else if (poll.app_requests == REQ_NONE) begin
        dec_start = poll.now_ms;
      end else begin
        dec_start = cur.phase_start;
      end
    end
  end

  // Wrapping elapsed time since the phase started
  assign elapsed = poll.now_ms - dec_start;

  // Advance the sequencer and record the poll history
  always_comb begin
    nxt             = cur;
    nxt.phase       = dec_phase;
    nxt.phase_start = dec_start;
    if (!poll.mode) begin
      nxt.last_rc_main = poll.rc_main_level;
      nxt.last_rc_aux  = poll.rc_aux_level;
    end else begin
      nxt.last_app_requests = poll.app_requests;
    end
    unique case (dec_phase)
      PH_PRESS1: begin
        if (elapsed < {16'd0, cfg.press_time_ms}) begin
          nxt.line_levels[LINE_ONE] = 1'b0;
        end else begin
          nxt.line_levels[LINE_ONE] = 1'b1;
          nxt.phase_start           = poll.now_ms;
        end
      end
      PH_PRESS2: begin
        if (elapsed < {16'd0, cfg.press_time_ms}) begin
          nxt.line_levels[LINE_TWO] = 1'b0;
        end else begin
          nxt.line_levels[LINE_TWO] = 1'b1;
          nxt.phase_start           = poll.now_ms;
        end
      end
      PH_SHORT3: begin
        if (elapsed < {16'd0, cfg.short_press_ms}) begin
          nxt.line_levels[LINE_THREE] = 1'b0;
        end else begin
          nxt.line_levels[LINE_THREE] = 1'b1;
          nxt.phase_start             = poll.now_ms;
          nxt.phase                   = PH_GAP;
        end
      end
      PH_LONG3: begin
        if (elapsed < {16'd0, cfg.long_press_ms}) begin
          nxt.line_levels[LINE_THREE] = 1'b0;
        end else begin
          nxt.line_levels[LINE_THREE] = 1'b1;
          nxt.phase_start             = poll.now_ms;
          nxt.phase                   = PH_IDLE;
        end
      end
      PH_GAP: begin
        if (elapsed >= {16'd0, cfg.gap_time_ms}) begin
          nxt.phase_start  = poll.now_ms;
          nxt.phase        = cur.repeat_count ? PH_LONG3 : PH_SHORT3;
          nxt.repeat_count = ~cur.repeat_count;
        end
      end
      default: begin
        // idle and the unused codes hold
        nxt.phase = dec_phase;
      end
    endcase
  end

endmodule

// ===== rtl/core/siren_button_pulse_sequencer_unit.sv =====
// Top level: poll stream in, button line levels and phase out, with configuration registers.
// An accepted input beat passes the input register, then the result register, to its result beat.
// One poll per cycle unless output stalls; state updates as a poll enters the result register.
// Input stays ready while a result waits, until the input register also holds a beat.
// Reset (rst, synchronous, active high): phase idle, all lines released, history and timer zero,
// configuration registers back to their default values.
module siren_button_pulse_sequencer_unit import sbps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low bit up: now_ms[31:0], rc_main_level[11:0], rc_aux_level[11:0],
  // app_siren_one, app_siren_two, app_siren_three, 5 zero bits
  input  logic [63:0] s_axis_tdata,
  // tuser: mode (0 remote poll, 1 app poll)
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low bit up: siren_one_line, siren_two_line, siren_three_line, phase_now[2:0],
  // 2 zero bits
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg;
  poll_t      poll;
  seq_state_t state;
  seq_state_t state_next;
  logic       in_valid;
  logic       out_valid;
  logic [5:0] out_data;
  logic       advance;

  // Move a poll forward when the result register is free or being emptied
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_data};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.switch_low_level    <= 12'd1000;
      cfg.switch_center_level <= 12'd1500;
      cfg.switch_high_level   <= 12'd2000;
      cfg.press_time_ms       <= 16'd100;
      cfg.short_press_ms      <= 16'd200;
      cfg.long_press_ms       <= 16'd500;
      cfg.gap_time_ms         <= 16'd70;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SWITCH_LOW:    cfg.switch_low_level    <= cfg_data[11:0];
        CFG_SWITCH_CENTER: cfg.switch_center_level <= cfg_data[11:0];
        CFG_SWITCH_HIGH:   cfg.switch_high_level   <= cfg_data[11:0];
        CFG_PRESS_TIME:    cfg.press_time_ms       <= cfg_data;
        CFG_SHORT_PRESS:   cfg.short_press_ms      <= cfg_data;
        CFG_LONG_PRESS:    cfg.long_press_ms       <= cfg_data;
        CFG_GAP_TIME:      cfg.gap_time_ms         <= cfg_data;
        default: begin
          // writes past the register list are dropped
          cfg.gap_time_ms <= cfg.gap_time_ms;
        end
      endcase
    end
  end

  // Input register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      poll.mode          <= s_axis_tuser[0];
      poll.now_ms        <= s_axis_tdata[31:0];
      poll.rc_main_level <= s_axis_tdata[43:32];
      poll.rc_aux_level  <= s_axis_tdata[55:44];
      poll.app_requests  <= s_axis_tdata[58:56];
    end
  end

  // Decode and sequence one poll
  sbps_step u_step (
    .cfg  (cfg),
    .poll (poll),
    .cur  (state),
    .nxt  (state_next)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= PH_IDLE;
      state.phase_start       <= 32'd0;
      state.repeat_count      <= 1'b0;
      state.last_rc_main      <= 12'd0;
      state.last_rc_aux       <= 12'd0;
      state.last_app_requests <= 3'd0;
      state.line_levels       <= 3'b111;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {state_next.phase, state_next.line_levels};
    end
  end

`ifndef NO_ASSERTIONS
  // A poll moved forward always shows up as a result beat
  assert property (@(posedge clk) disable iff (rst) advance |=> m_axis_tvalid)
    else $error("result beat missing after a poll advanced");

  // The sequencer state holds while no poll moves forward
  assert property (@(posedge clk) disable iff (rst) !advance |=> $stable(state))
    else $error("sequencer state changed without a poll");

  // A full input register with a stalled result blocks new input
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both registers are full");

  // The long press is entered only from the gap
  assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_LONG3 && $past(state.phase) != PH_LONG3) |->
      ($past(state.phase) == PH_GAP))
    else $error("long press entered from a phase other than gap");
`endif

endmodule

// ===== dv/siren_button_pulse_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the siren button pulse sequencer unit.
module siren_button_pulse_sequencer_unit_tb import sbps_pkg::*;;

  localparam logic        MODE_REMOTE = 1'b0;
  localparam logic        MODE_APP    = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_LIMIT = 100;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tdata, low bit up: now_ms[31:0], rc_main_level[11:0], rc_aux_level[11:0],
  // app_siren_one, app_siren_two, app_siren_three, 5 zero bits
  logic [63:0] s_axis_tdata;
  // tuser: mode (0 remote poll, 1 app poll)
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tdata, low bit up: siren_one_line, siren_two_line, siren_three_line, phase_now[2:0],
  // 2 zero bits
  logic [7:0]  m_axis_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  typedef struct packed {
    logic [2:0] lines;
    logic [2:0] phase;
  } line_report_t;

  // Predicts line levels and phase per poll and checks result beats in order
  class siren_line_scoreboard;
    cfg_t         cfg;
    seq_state_t   st;
    line_report_t expected_lines[$];
    int unsigned  mismatches;
    int unsigned  beats_checked;

    function new();
      cfg.switch_low_level    = 12'd1000;
      cfg.switch_center_level = 12'd1500;
      cfg.switch_high_level   = 12'd2000;
      cfg.press_time_ms       = 16'd100;
      cfg.short_press_ms      = 16'd200;
      cfg.long_press_ms       = 16'd500;
      cfg.gap_time_ms         = 16'd70;
      st.phase             = PH_IDLE;
      st.phase_start       = '0;
      st.repeat_count      = 1'b0;
      st.last_rc_main      = '0;
      st.last_rc_aux       = '0;
      st.last_app_requests = REQ_NONE;
      st.line_levels       = 3'b111;
      mismatches    = 0;
      beats_checked = 0;
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction

    // Duration of the current phase, zero where no timer runs
    function logic [15:0] phase_length();
      case (st.phase)
        PH_PRESS1, PH_PRESS2: return cfg.press_time_ms;
        PH_SHORT3:            return cfg.short_press_ms;
        PH_LONG3:             return cfg.long_press_ms;
        PH_GAP:               return cfg.gap_time_ms;
        default:              return 16'd0;
      endcase
    endfunction

    function void start_phase(logic [2:0] p, logic [31:0] now);
      st.phase       = p;
      st.phase_start = now;
    endfunction

    // Hold the line low while the press lasts; release and restart the timer after
    function bit timed_press(int unsigned line, logic [15:0] dur, logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - st.phase_start;
      if (elapsed < {16'd0, dur}) begin
        st.line_levels[line] = 1'b0;
        return 1'b0;
      end
      st.line_levels[line] = 1'b1;
      st.phase_start       = now;
      return 1'b1;
    endfunction

    function void advance(logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - st.phase_start;
      case (st.phase)
        PH_PRESS1: void'(timed_press(LINE_ONE, cfg.press_time_ms, now));
        PH_PRESS2: void'(timed_press(LINE_TWO, cfg.press_time_ms, now));
        PH_SHORT3: begin
          if (timed_press(LINE_THREE, cfg.short_press_ms, now)) st.phase = PH_GAP;
        end
        PH_LONG3: begin
          if (timed_press(LINE_THREE, cfg.long_press_ms, now)) st.phase = PH_IDLE;
        end
        PH_GAP: begin
          if (elapsed >= {16'd0, cfg.gap_time_ms}) begin
            // second gap leads to the long press, first one to another short press
            if (st.repeat_count) begin
              st.phase        = PH_LONG3;
              st.repeat_count = 1'b0;
            end else begin
              st.phase        = PH_SHORT3;
              st.repeat_count = 1'b1;
            end
            st.phase_start = now;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_poll(logic mode, logic [31:0] now, logic [11:0] main_lv,
                            logic [11:0] aux_lv, logic [2:0] req);
      line_report_t want;
      if (mode == MODE_REMOTE) begin
        // first matching switch move wins
        if (main_lv == cfg.switch_low_level && st.last_rc_main == cfg.switch_center_level)
          start_phase(PH_PRESS1, now);
        else if (main_lv == cfg.switch_center_level && st.last_rc_main == cfg.switch_low_level)
          start_phase(PH_PRESS1, now);
        else if (main_lv == cfg.switch_high_level && st.last_rc_main == cfg.switch_center_level)
          start_phase(PH_PRESS2, now);
        else if (main_lv == cfg.switch_center_level && st.last_rc_main == cfg.switch_high_level)
          start_phase(PH_PRESS2, now);
        else if (aux_lv == cfg.switch_high_level && st.last_rc_aux == cfg.switch_low_level)
          start_phase(PH_SHORT3, now);
        else if (aux_lv == cfg.switch_low_level && st.last_rc_aux == cfg.switch_high_level)
          start_phase(PH_SHORT3, now);
        advance(now);
        st.last_rc_main = main_lv;
        st.last_rc_aux  = aux_lv;
      end else begin
        if (req != st.last_app_requests) begin
          case (req)
            REQ_ONE:   start_phase(PH_PRESS1, now);
            REQ_TWO:   start_phase(PH_PRESS2, now);
            REQ_THREE: start_phase(PH_SHORT3, now);
            REQ_NONE:  st.phase_start = now;
            default: ;
          endcase
        end
        st.last_app_requests = req;
        advance(now);
      end
      want.lines = st.line_levels;
      want.phase = st.phase;
      expected_lines.push_back(want);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      // keep the log bounded when everything goes wrong
      if (mismatches <= PRINT_LIMIT)
        $display("[%0t] mismatch at result beat %0d: %s", $time, beats_checked, msg);
    endtask

    task check_lines(logic [7:0] beat);
      line_report_t want;
      beats_checked++;
      if (expected_lines.size() == 0) begin
        report_mismatch($sformatf("beat 0x%02h with no poll outstanding", beat));
      end else begin
        want = expected_lines.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (beat[i] !== want.lines[i])
            report_mismatch($sformatf("siren %0d line got %b expected %b",
                                      i + 1, beat[i], want.lines[i]));
        end
        if (beat[5:3] !== want.phase)
          report_mismatch($sformatf("phase_now got %0d expected %0d", beat[5:3], want.phase));
      end
    endtask
  endclass

  siren_line_scoreboard line_check;
  logic [31:0] clock_ms;
  bit          tx_idle;
  bit          rx_idle;
  bit          quiet;
  int unsigned stall_left;
  int unsigned cycle_count;

  siren_button_pulse_sequencer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side in random bursts while the receiver is set to idle
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) line_check.check_lines(m_axis_tdata);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic cfg_t make_cfg(logic [11:0] lo, logic [11:0] ce, logic [11:0] hi,
                                    logic [15:0] press, logic [15:0] shrt,
                                    logic [15:0] lng, logic [15:0] gap);
    cfg_t c;
    c.switch_low_level    = lo;
    c.switch_center_level = ce;
    c.switch_high_level   = hi;
    c.press_time_ms       = press;
    c.short_press_ms      = shrt;
    c.long_press_ms       = lng;
    c.gap_time_ms         = gap;
    return c;
  endfunction

  function automatic logic [11:0] pick_main_level();
    case ($urandom_range(0, 3))
      0:       return line_check.cfg.switch_low_level;
      1:       return line_check.cfg.switch_center_level;
      2:       return line_check.cfg.switch_high_level;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [11:0] pick_aux_level();
    case ($urandom_range(0, 2))
      0:       return line_check.cfg.switch_low_level;
      1:       return line_check.cfg.switch_high_level;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Mostly small forward steps, some hits on the phase boundary, some wild jumps
  function automatic logic [31:0] pick_time(int unsigned step_max);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return clock_ms;
      2, 3:    return line_check.st.phase_start + {16'd0, line_check.phase_length()}
                      - $urandom_range(0, 1);
      default: return clock_ms + $urandom_range(0, step_max);
    endcase
  endfunction

  // Present one poll, optionally after an idle burst, and note it on acceptance
  task automatic send_poll(logic mode, logic [31:0] now, logic [11:0] main_lv,
                           logic [11:0] aux_lv, logic [2:0] req);
    int unsigned gap_len;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap_len = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap_len) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, req, aux_lv, main_lv, now};
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    line_check.note_poll(mode, now, main_lv, aux_lv, req);
    @(negedge clk);
  endtask

  task automatic poll_at_step(int unsigned dt, logic mode, logic [11:0] main_lv,
                              logic [11:0] aux_lv, logic [2:0] req);
    clock_ms = clock_ms + dt;
    send_poll(mode, clock_ms, main_lv, aux_lv, req);
  endtask

  task automatic send_random_poll(int unsigned step_max);
    logic        mode;
    logic [11:0] main_lv;
    logic [11:0] aux_lv;
    logic [2:0]  req;
    int unsigned pick;
    mode    = 1'($urandom_range(0, 1));
    main_lv = line_check.st.last_rc_main;
    aux_lv  = line_check.st.last_rc_aux;
    req     = line_check.st.last_app_requests;
    pick    = $urandom_range(0, 99);
    if (pick >= 85) begin
      // noise
      main_lv = 12'($urandom_range(0, 4095));
      aux_lv  = 12'($urandom_range(0, 4095));
      req     = 3'($urandom_range(0, 7));
    end else if (pick >= 55) begin
      // move a switch or a request, likely starting a phase
      if (mode == MODE_REMOTE) begin
        case ($urandom_range(0, 2))
          0: main_lv = pick_main_level();
          1: aux_lv  = pick_aux_level();
          default: begin
            main_lv = pick_main_level();
            aux_lv  = pick_aux_level();
          end
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0:       req = REQ_ONE;
          1:       req = REQ_TWO;
          2:       req = REQ_THREE;
          default: req = REQ_NONE;
        endcase
      end
    end
    // otherwise hold the inputs so running phases play out
    // fields the poll kind ignores carry random bits
    if (mode == MODE_REMOTE) begin
      req = 3'($urandom_range(0, 7));
    end else begin
      main_lv = 12'($urandom_range(0, 4095));
      aux_lv  = 12'($urandom_range(0, 4095));
    end
    clock_ms = pick_time(step_max);
    send_poll(mode, clock_ms, main_lv, aux_lv, req);
  endtask

  task automatic run_random(int unsigned count, int unsigned step_max);
    for (int i = 0; i < count; i++) begin
      // alternate stretches with and without idling
      if (i % 40 == 0) begin
        tx_idle = !quiet && $urandom_range(0, 3) != 0;
        rx_idle = !quiet && $urandom_range(0, 3) != 0;
      end
      send_random_poll(step_max);
    end
  endtask

  // Drop valid and wait until every expected result beat has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (line_check.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic reconfigure(cfg_t c);
    wait_drained();
    write_reg(CFG_SWITCH_LOW,    {4'b0, c.switch_low_level});
    write_reg(CFG_SWITCH_CENTER, {4'b0, c.switch_center_level});
    write_reg(CFG_SWITCH_HIGH,   {4'b0, c.switch_high_level});
    write_reg(CFG_PRESS_TIME,    c.press_time_ms);
    write_reg(CFG_SHORT_PRESS,   c.short_press_ms);
    write_reg(CFG_LONG_PRESS,    c.long_press_ms);
    write_reg(CFG_GAP_TIME,      c.gap_time_ms);
    cfg_we <= 1'b0;
    line_check.cfg = c;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SWITCH_LOW;
    cfg_data      = '0;
    stall_left    = 0;
    cycle_count   = 0;
    quiet         = 1'b0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    line_check    = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed polls on the reset settings, timestamps wrapping through zero
    clock_ms = 32'hFFFF_FF80;
    poll_at_step(0,   MODE_REMOTE, 12'd1500, 12'd1000, REQ_NONE);
    poll_at_step(10,  MODE_REMOTE, 12'd1000, 12'd1000, REQ_NONE);  // center to low
    poll_at_step(50,  MODE_REMOTE, 12'd1000, 12'd1000, REQ_NONE);
    poll_at_step(50,  MODE_REMOTE, 12'd1000, 12'd1000, REQ_NONE);  // press ends, repeats
    poll_at_step(60,  MODE_REMOTE, 12'd1500, 12'd1000, REQ_NONE);  // low to center
    poll_at_step(5,   MODE_REMOTE, 12'd2000, 12'd1000, REQ_NONE);  // center to high
    poll_at_step(5,   MODE_REMOTE, 12'd1500, 12'd1000, REQ_NONE);  // high to center
    poll_at_step(5,   MODE_REMOTE, 12'd1500, 12'd2000, REQ_NONE);  // aux low to high
    poll_at_step(200, MODE_REMOTE, 12'd1500, 12'd2000, REQ_NONE);  // into first gap
    poll_at_step(70,  MODE_REMOTE, 12'd1500, 12'd2000, REQ_NONE);  // second short press
    poll_at_step(199, MODE_REMOTE, 12'd1500, 12'd2000, REQ_NONE);
    poll_at_step(1,   MODE_REMOTE, 12'd1500, 12'd2000, REQ_NONE);  // into second gap
    poll_at_step(70,  MODE_REMOTE, 12'd1500, 12'd2000, REQ_NONE);  // long press
    poll_at_step(500, MODE_REMOTE, 12'd1500, 12'd2000, REQ_NONE);  // back to idle
    poll_at_step(3,   MODE_REMOTE, 12'd1500, 12'd1000, REQ_NONE);  // aux high to low
    poll_at_step(3,   MODE_REMOTE, 12'd4095, 12'd0,    REQ_NONE);  // levels matching nothing
    poll_at_step(3,   MODE_REMOTE, 12'd0,    12'd4095, 3'b111);
    poll_at_step(3,   MODE_APP,    12'd0,    12'd0,    REQ_ONE);
    poll_at_step(3,   MODE_APP,    12'd0,    12'd0,    REQ_TWO);
    poll_at_step(3,   MODE_APP,    12'd0,    12'd0,    REQ_THREE);
    poll_at_step(3,   MODE_APP,    12'd0,    12'd0,    REQ_NONE);  // all off restarts timer
    poll_at_step(3,   MODE_APP,    12'd0,    12'd0,    3'b011);    // two requests on
    poll_at_step(3,   MODE_APP,    12'd0,    12'd0,    3'b111);
    poll_at_step(3,   MODE_APP,    12'd0,    12'd0,    3'b111);    // unchanged
    poll_at_step(3,   MODE_APP,    12'd0,    12'd0,    REQ_NONE);

    run_random(200, 300);
    // Short timings, full level span
    reconfigure(make_cfg(12'd0, 12'd2048, 12'd4095, 16'd1, 16'd3, 16'd5, 16'd2));
    run_random(250, 8);
    // Longest timings, low and high levels equal
    reconfigure(make_cfg(12'd4095, 12'd0, 12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    run_random(150, 40000);
    // All levels equal, zero timings
    reconfigure(make_cfg(12'd777, 12'd777, 12'd777, 16'd0, 16'd0, 16'd0, 16'd0));
    run_random(150, 4);
    reconfigure(make_cfg(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                         12'($urandom_range(0, 4095)), 16'($urandom_range(0, 600)),
                         16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                         16'($urandom_range(0, 600))));
    run_random(125, 400);
    // Hold off the sender until the block has drained
    wait_drained();
    run_random(125, 400);
    // Final stretch at full rate on both sides
    quiet = 1'b1;
    rx_idle = 1'b0;
    reconfigure(make_cfg(12'd4095, 12'd2047, 12'd0, 16'd20, 16'd30, 16'd60, 16'd10));
    run_random(110, 25);
    wait_drained();

    if (line_check.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
